// ===== rtl/core/job_stack_with_key_search_macros.svh =====
// ---------------------------------------------------------------------------
// job_stack_with_key_search_macros.svh
// Assertion macros shared by the job stack checker.
// ---------------------------------------------------------------------------
`ifndef JOB_STACK_WITH_KEY_SEARCH_MACROS_SVH
`define JOB_STACK_WITH_KEY_SEARCH_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define JSKS_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define JSKS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also runs through reset.
`define JSKS_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/jsks_pkg.sv =====
// ---------------------------------------------------------------------------
// jsks_pkg
// Shared widths, codes and types of the job stack.
// ---------------------------------------------------------------------------
package jsks_pkg;

   localparam int KindBits    = 3;
   localparam int IdBits      = 31;
   localparam int TypeBits    = 2;
   localparam int PayBits     = 32;
   localparam int StatusBits  = 2;
   localparam int PayMaxBits  = 64;
   localparam int ReqDataBits = 72;
   localparam int RspDataBits = 72;

   localparam int DepthDefault       = 128;
   localparam int PayloadBitsDefault = 32;

   // operation codes
   localparam logic [KindBits-1:0] KindPush     = 3'd0;
   localparam logic [KindBits-1:0] KindPull     = 3'd1;
   localparam logic [KindBits-1:0] KindPeek     = 3'd2;
   localparam logic [KindBits-1:0] KindFindId   = 3'd3;
   localparam logic [KindBits-1:0] KindFindType = 3'd4;
   localparam logic [KindBits-1:0] KindDeleteId = 3'd5;

   // result status codes
   localparam logic [StatusBits-1:0] StatDone = 2'd0;
   localparam logic [StatusBits-1:0] StatFull = 2'd1;
   localparam logic [StatusBits-1:0] StatNone = 2'd2;

   // per-cycle move command broadcast to every cell
   typedef struct packed {
      logic shift_down;  // push: every cell takes its newer neighbor
      logic shift_up;    // pull/rotate/drop: every cell takes its older neighbor
      logic wrap;        // rotate: last occupied cell takes the top record
   } cell_cmd_type;

   // one result item, status in the low bits
   typedef struct packed {
      logic [PayBits-1:0]    found_payload;
      logic [TypeBits-1:0]   found_type;
      logic [IdBits-1:0]     found_id;
      logic [StatusBits-1:0] status;
   } rsp_rec_type;

endpackage

// ===== rtl/core/job_stack_with_key_search.sv =====
// ---------------------------------------------------------------------------
// job_stack_with_key_search
// Bounded LIFO table of job records with search and delete by key.
// ---------------------------------------------------------------------------
// Usage:
//  - req_* carries one operation per transfer: push, pull newest, peek newest,
//    find newest by id, find newest by type, delete newest by id.
//  - rsp_* returns exactly one result per operation, in order: status and the
//    record concerned (zeros when the status is not done).
//  - Records live in a row of DEPTH cells, newest in cell 0. Push shifts the
//    row down and pull shifts it up.
//  - Push, pull, peek, unknown kinds and any operation on an empty table are
//    answered without a rotation: the result is registered into rsp, or into
//    the skid register while rsp is stalled, and the control stays idle.
//  - Find and delete rotate the occupied cells past cell 0, one per cycle,
//    comparing the key there; the whole ring is turned so order is restored.
//    They visit all N held records (up to DEPTH), then give the result.
//    Delete drops the matching record instead of rotating it.
//  - A stalled result sits in rsp while one more result waits in a skid
//    register; req_tready drops only when that skid register is full or a
//    rotation is running.
//  - Synchronous reset empties the table and clears both result registers.
// ---------------------------------------------------------------------------
module job_stack_with_key_search #(
   parameter int DEPTH        = jsks_pkg::DepthDefault,
   parameter int PAYLOAD_BITS = jsks_pkg::PayloadBitsDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // kind[2:0], job_id[33:3], job_type[35:34], job_payload[67:36], zero pad
   input  logic [jsks_pkg::ReqDataBits-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // status[1:0], found_id[32:2], found_type[34:33], found_payload[66:35], pad
   output logic [jsks_pkg::RspDataBits-1:0]   rsp_tdata
);

   localparam int FillBits = $clog2(DEPTH + 1);
   localparam int PadBits  = jsks_pkg::RspDataBits - $bits(jsks_pkg::rsp_rec_type);

   // control state codes
   localparam logic StIdle = 1'b0;
   localparam logic StScan = 1'b1;

   // ---- request fields
   logic [jsks_pkg::KindBits-1:0] req_kind;
   logic [jsks_pkg::IdBits-1:0]   req_id;
   logic [jsks_pkg::TypeBits-1:0] req_type;
   logic [jsks_pkg::PayBits-1:0]  req_pay;
   logic [jsks_pkg::PayMaxBits-1:0] req_pay_wide;
   logic [PAYLOAD_BITS-1:0]       req_pay_store;
   logic                          accept;

   assign req_kind     = req_tdata[2:0];
   assign req_id       = req_tdata[33:3];
   assign req_type     = req_tdata[35:34];
   assign req_pay      = req_tdata[67:36];
   assign req_pay_wide = {{(jsks_pkg::PayMaxBits - jsks_pkg::PayBits){1'b0}}, req_pay};
   assign req_pay_store = req_pay_wide[PAYLOAD_BITS-1:0];
   assign accept       = req_tvalid && req_tready;

   // ---- cell row
   jsks_pkg::cell_cmd_type          cmd;
   logic                            cell_occ  [DEPTH];
   logic [jsks_pkg::IdBits-1:0]     cell_id   [DEPTH];
   logic [jsks_pkg::TypeBits-1:0]   cell_type [DEPTH];
   logic [PAYLOAD_BITS-1:0]         cell_pay  [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic                          up_occ;
      logic [jsks_pkg::IdBits-1:0]   up_id;
      logic [jsks_pkg::TypeBits-1:0] up_type;
      logic [PAYLOAD_BITS-1:0]       up_pay;
      logic                          dn_occ;
      logic [jsks_pkg::IdBits-1:0]   dn_id;
      logic [jsks_pkg::TypeBits-1:0] dn_type;
      logic [PAYLOAD_BITS-1:0]       dn_pay;

      if (i == 0) begin : g_top
         assign up_occ  = 1'b1;
         assign up_id   = req_id;
         assign up_type = req_type;
         assign up_pay  = req_pay_store;
      end else begin : g_mid
         assign up_occ  = cell_occ[i-1];
         assign up_id   = cell_id[i-1];
         assign up_type = cell_type[i-1];
         assign up_pay  = cell_pay[i-1];
      end

      if (i < DEPTH - 1) begin : g_link
         assign dn_occ  = cell_occ[i+1];
         assign dn_id   = cell_id[i+1];
         assign dn_type = cell_type[i+1];
         assign dn_pay  = cell_pay[i+1];
      end else begin : g_end
         assign dn_occ  = 1'b0;
         assign dn_id   = '0;
         assign dn_type = '0;
         assign dn_pay  = '0;
      end

      jsks_cell #(
         .PAYLOAD_BITS (PAYLOAD_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .above_occ  (up_occ),
         .above_id   (up_id),
         .above_type (up_type),
         .above_pay  (up_pay),
         .below_occ  (dn_occ),
         .below_id   (dn_id),
         .below_type (dn_type),
         .below_pay  (dn_pay),
         .top_id     (cell_id[0]),
         .top_type   (cell_type[0]),
         .top_pay    (cell_pay[0]),
         .occ        (cell_occ[i]),
         .id         (cell_id[i]),
         .job_type   (cell_type[i]),
         .pay        (cell_pay[i])
      );
   end

   // top record as a result, payload widened to the output field
   logic [jsks_pkg::PayMaxBits:0]  top_pay_wide;
   jsks_pkg::rsp_rec_type          top_rec;
   jsks_pkg::rsp_rec_type          push_rec;
   logic [jsks_pkg::PayMaxBits:0]  push_pay_wide;

   assign top_pay_wide  = {{(jsks_pkg::PayMaxBits + 1 - PAYLOAD_BITS){1'b0}}, cell_pay[0]};
   assign push_pay_wide = {{(jsks_pkg::PayMaxBits + 1 - PAYLOAD_BITS){1'b0}}, req_pay_store};

   always_comb begin
      top_rec.status         = jsks_pkg::StatDone;
      top_rec.found_id       = cell_id[0];
      top_rec.found_type     = cell_type[0];
      top_rec.found_payload  = top_pay_wide[jsks_pkg::PayBits-1:0];
      push_rec.status        = jsks_pkg::StatDone;
      push_rec.found_id      = req_id;
      push_rec.found_type    = req_type;
      push_rec.found_payload = push_pay_wide[jsks_pkg::PayBits-1:0];
   end

   // ---- control registers
   logic                          state_ff,   state_in;
   logic [FillBits-1:0]           fill_ff,    fill_in;
   logic [FillBits-1:0]           steps_ff,   steps_in;
   logic [jsks_pkg::IdBits-1:0]   key_id_ff,  key_id_in;
   logic [jsks_pkg::TypeBits-1:0] key_type_ff, key_type_in;
   logic                          by_type_ff, by_type_in;
   logic                          del_ff,     del_in;
   logic                          hit_ff,     hit_in;
   jsks_pkg::rsp_rec_type         found_ff,   found_in;

   // result of this cycle, if any
   logic                          res_valid;
   jsks_pkg::rsp_rec_type         res_rec;
   jsks_pkg::rsp_rec_type         none_rec;
   jsks_pkg::rsp_rec_type         full_rec;

   logic                          empty;
   logic                          full;
   logic                          step_match;

   assign empty = (fill_ff == '0);
   assign full  = (fill_ff == FillBits'(DEPTH));

   // cell 0 is always occupied while scanning
   assign step_match = !hit_ff &&
      (by_type_ff ? (cell_type[0] == key_type_ff) : (cell_id[0] == key_id_ff));

   always_comb begin
      none_rec        = '0;
      none_rec.status = jsks_pkg::StatNone;
      full_rec        = '0;
      full_rec.status = jsks_pkg::StatFull;
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      steps_in    = steps_ff;
      key_id_in   = key_id_ff;
      key_type_in = key_type_ff;
      by_type_in  = by_type_ff;
      del_in      = del_ff;
      hit_in      = hit_ff;
      found_in    = found_ff;
      cmd         = '0;
      res_valid   = 1'b0;
      res_rec     = none_rec;

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               res_valid = 1'b1;
               unique case (req_kind)
                  jsks_pkg::KindPush: begin
                     if (full) begin
                        res_rec = full_rec;
                     end else begin
                        cmd.shift_down = 1'b1;
                        fill_in        = FillBits'(fill_ff + 1'b1);
                        res_rec        = push_rec;
                     end
                  end
                  jsks_pkg::KindPull: begin
                     if (!empty) begin
                        cmd.shift_up = 1'b1;
                        fill_in      = FillBits'(fill_ff - 1'b1);
                        res_rec      = top_rec;
                     end
                  end
                  jsks_pkg::KindPeek: begin
                     if (!empty) begin
                        res_rec = top_rec;
                     end
                  end
                  jsks_pkg::KindFindId, jsks_pkg::KindFindType,
                  jsks_pkg::KindDeleteId: begin
                     if (!empty) begin
                        // result comes at the end of the rotation
                        res_valid   = 1'b0;
                        state_in    = StScan;
                        steps_in    = fill_ff;
                        key_id_in   = req_id;
                        key_type_in = req_type;
                        by_type_in  = (req_kind == jsks_pkg::KindFindType);
                        del_in      = (req_kind == jsks_pkg::KindDeleteId);
                        hit_in      = 1'b0;
                     end
                  end
                  default: begin
                     res_rec = none_rec;
                  end
               endcase
            end
         end
         StScan: begin
            cmd.shift_up = 1'b1;
            cmd.wrap     = !(step_match && del_ff);
            if (step_match) begin
               hit_in   = 1'b1;
               found_in = top_rec;
               if (del_ff) begin
                  fill_in = FillBits'(fill_ff - 1'b1);
               end
            end
            steps_in = FillBits'(steps_ff - 1'b1);
            if (steps_ff == FillBits'(1)) begin
               state_in  = StIdle;
               res_valid = 1'b1;
               if (hit_ff) begin
                  res_rec = found_ff;
               end else if (step_match) begin
                  res_rec = top_rec;
               end else begin
                  res_rec = none_rec;
               end
            end
         end
         default: begin
            state_in = StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         fill_ff  <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff    <= steps_in;
      key_id_ff   <= key_id_in;
      key_type_ff <= key_type_in;
      by_type_ff  <= by_type_in;
      del_ff      <= del_in;
      found_ff    <= found_in;
   end

   // ---- output register plus one-entry skid
   logic                  rsp_valid_ff,  rsp_valid_in;
   jsks_pkg::rsp_rec_type rsp_ff,        rsp_in;
   logic                  pend_valid_ff, pend_valid_in;
   jsks_pkg::rsp_rec_type pend_ff,       pend_in;
   logic                  rsp_free;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == StIdle) && !pend_valid_ff;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      // a new result only appears while the skid entry is empty
      priority if (res_valid) begin
         if (rsp_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res_rec;
         end else begin
            pend_valid_in = 1'b1;
            pend_in       = res_rec;
         end
      end else if (rsp_free) begin
         rsp_valid_in  = pend_valid_ff;
         rsp_in        = pend_ff;
         pend_valid_in = 1'b0;
      end else begin
         // receiver stalled, nothing new: hold
         pend_valid_in = pend_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PadBits{1'b0}}, rsp_ff};

endmodule

// ===== rtl/core/jsks_cell.sv =====
// ---------------------------------------------------------------------------
// jsks_cell
// One slot of the shift-register stack: holds a record and an occupied flag.
// ---------------------------------------------------------------------------
module jsks_cell #(
   parameter int PAYLOAD_BITS = jsks_pkg::PayloadBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  jsks_pkg::cell_cmd_type      cmd,
   // newer neighbor
   input  logic                        above_occ,
   input  logic [jsks_pkg::IdBits-1:0]   above_id,
   input  logic [jsks_pkg::TypeBits-1:0] above_type,
   input  logic [PAYLOAD_BITS-1:0]     above_pay,
   // older neighbor
   input  logic                        below_occ,
   input  logic [jsks_pkg::IdBits-1:0]   below_id,
   input  logic [jsks_pkg::TypeBits-1:0] below_type,
   input  logic [PAYLOAD_BITS-1:0]     below_pay,
   // top record, for rotation
   input  logic [jsks_pkg::IdBits-1:0]   top_id,
   input  logic [jsks_pkg::TypeBits-1:0] top_type,
   input  logic [PAYLOAD_BITS-1:0]     top_pay,
   // this cell
   output logic                        occ,
   output logic [jsks_pkg::IdBits-1:0]   id,
   output logic [jsks_pkg::TypeBits-1:0] job_type,
   output logic [PAYLOAD_BITS-1:0]     pay
);

   logic                          occ_ff,  occ_in;
   logic [jsks_pkg::IdBits-1:0]   id_ff,   id_in;
   logic [jsks_pkg::TypeBits-1:0] type_ff, type_in;
   logic [PAYLOAD_BITS-1:0]       pay_ff,  pay_in;

   always_comb begin
      occ_in  = occ_ff;
      id_in   = id_ff;
      type_in = type_ff;
      pay_in  = pay_ff;
      priority if (cmd.shift_down) begin
         occ_in  = above_occ;
         id_in   = above_id;
         type_in = above_type;
         pay_in  = above_pay;
      end else if (cmd.shift_up) begin
         if (below_occ) begin
            occ_in  = 1'b1;
            id_in   = below_id;
            type_in = below_type;
            pay_in  = below_pay;
         end else if (cmd.wrap && occ_ff) begin
            // last occupied slot closes the ring
            occ_in  = 1'b1;
            id_in   = top_id;
            type_in = top_type;
            pay_in  = top_pay;
         end else begin
            occ_in  = 1'b0;
         end
      end else begin
         // no move: hold
         occ_in  = occ_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      id_ff   <= id_in;
      type_ff <= type_in;
      pay_ff  <= pay_in;
   end

   assign occ      = occ_ff;
   assign id       = id_ff;
   assign job_type = type_ff;
   assign pay      = pay_ff;

endmodule

// ===== rtl/core/jsks_checker.sv =====
// ---------------------------------------------------------------------------
// jsks_checker
// Port-level checks of the job stack, bound to the top level.
// ---------------------------------------------------------------------------
`include "job_stack_with_key_search_macros.svh"

module jsks_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [jsks_pkg::ReqDataBits-1:0] req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [jsks_pkg::RspDataBits-1:0] rsp_tdata
);

   // held result stays put
   `JSKS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp changed while stalled")

   // a refused or empty result carries no record
   `JSKS_ASSERT_SAME(a_rsp_zero, clock, reset, rsp_tvalid && (rsp_tdata[1:0] != jsks_pkg::StatDone), rsp_tdata[66:2] == '0, "record bits set on failed operation")

   // push seen with a free output answers next cycle with the pushed id or full
   `JSKS_ASSERT_NEXT(a_push_echo, clock, reset, req_tvalid && req_tready && (req_tdata[2:0] == jsks_pkg::KindPush) && (!rsp_tvalid || rsp_tready), rsp_tvalid && ((rsp_tdata[1:0] == jsks_pkg::StatFull) || (rsp_tdata[32:2] == $past(req_tdata[33:3]))), "push result mismatch")

   // reset leaves no result pending
   `JSKS_ASSERT_NEXT_ALWAYS(a_reset_clear, clock, reset, !rsp_tvalid, "rsp valid after reset")

endmodule

bind job_stack_with_key_search jsks_checker u_jsks_checker (.*);
